// ===== sv/cks_pkg.sv =====
// Shared types and constants of the cuckoo hash set.
package cks_pkg;

  localparam int KeyW            = 31;
  localparam int KickW           = 8;
  localparam logic [KickW-1:0] KickReset = 8'd32;
  localparam int SlotBitsDefault = 10;
  localparam int QDepth          = 2;
  localparam int QPtrW           = $clog2(QDepth);

  typedef enum logic [1:0] {
    OpLookup = 2'd0,
    OpInsert = 2'd1,
    OpRemove = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    OcDone    = 3'd0,
    OcAbsent  = 3'd1,
    OcPresent = 3'd2,
    OcZero    = 3'd3,
    OcFull    = 3'd4
  } outc_e;

  typedef struct packed {
    op_e             op;
    logic            zero;
    logic [KeyW-1:0] key;
  } cmd_t;

endpackage

// ===== sv/cks_if.sv =====
// Request and response channel interfaces of the cuckoo hash set.
interface cks_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [cks_pkg::KeyW-1:0] key;

  modport source (output valid, req_type, key, input ready);
  modport sink (input valid, req_type, key, output ready);
endinterface

interface cks_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     success;
  logic [2:0]               outcome;
  logic [cks_pkg::KeyW-1:0] dropped_key;

  modport source (output valid, success, outcome, dropped_key, input ready);
  modport sink (input valid, success, outcome, dropped_key, output ready);
endinterface

// ===== sv/cks_front.sv =====
// Front stage: accepts requests, flags zero keys, folds unused codes into lookups.
module cks_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  cks_req_if.sink         req_i,
  input  logic            open_i,
  output logic            cmd_valid_o,
  output cks_pkg::cmd_t   cmd_o,
  input  logic            cmd_ready_i
);

  logic          valid_q, valid_d;
  cks_pkg::cmd_t cmd_q, cmd_d;
  cks_pkg::op_e  op;
  logic          take;

  assign req_i.ready = open_i && (!valid_q || cmd_ready_i);
  assign take        = req_i.valid && req_i.ready;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    unique case (req_i.req_type)
      cks_pkg::OpInsert: op = cks_pkg::OpInsert;
      cks_pkg::OpRemove: op = cks_pkg::OpRemove;
      default:           op = cks_pkg::OpLookup;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (take) begin
      valid_d     = 1'b1;
      cmd_d.op    = op;
      cmd_d.zero  = (req_i.key == '0);
      cmd_d.key   = req_i.key;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ===== sv/cks_fifo.sv =====
// Short command queue between the front and back stages.
module cks_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  cks_pkg::cmd_t push_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output cks_pkg::cmd_t pop_o,
  input  logic          pop_ready_i
);

  localparam int PW = cks_pkg::QPtrW;

  cks_pkg::cmd_t    mem_q [cks_pkg::QDepth];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(cks_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i;
    end
  end

endmodule

// ===== sv/cks_back.sv =====
// Back stage: slot table, clearing pass, lookup/insert/remove and the kick loop.
module cks_back #(
  parameter int SlotBits = cks_pkg::SlotBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  cks_pkg::cmd_t             cmd_i,
  output logic                      cmd_ready_o,
  output logic                      open_o,
  input  logic                      kick_limit_we_i,
  input  logic [cks_pkg::KickW-1:0] kick_limit_i,
  cks_rsp_if.source                 rsp_o
);

  localparam int Slots = 1 << SlotBits;
  localparam int KW    = (2 * SlotBits > cks_pkg::KeyW) ? 2 * SlotBits : cks_pkg::KeyW;
  localparam int SB    = SlotBits;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StLook  = 3'd2;
  localparam logic [2:0] StKick  = 3'd3;
  localparam logic [2:0] StKchk  = 3'd4;

  typedef logic [cks_pkg::KeyW-1:0] key_t;
  typedef logic [SB-1:0]            idx_t;

  logic [2:0]               state_q, state_d;
  idx_t                     clr_q, clr_d;
  logic [cks_pkg::KickW-1:0] limit_q, moves_q, moves_d;
  cks_pkg::op_e             op_q, op_d;
  key_t                     key_q, key_d, hand_q, hand_d, y_q, y_d, bypv_q, bypv_d;
  idx_t                     p0_q, p0_d, p1_q, p1_d, pos_q, pos_d, alt_q, alt_d;
  logic                     byp_q, byp_d;

  key_t                     mem_q [Slots];
  key_t                     rda_q, rdb_q, wd, v;
  idx_t                     ra_a, ra_b, wa, alt, yb;
  logic                     we, rd_en;
  logic [KW-1:0]            kx, yx;

  logic                     out_valid_q, out_valid_d, ok_q, ok_d;
  cks_pkg::outc_e           oc_q, oc_d;
  key_t                     drop_q, drop_d;
  logic                     out_free;

  assign out_free          = !out_valid_q || rsp_o.ready;
  assign open_o            = (state_q != StClear);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.success     = ok_q;
  assign rsp_o.outcome     = oc_q;
  assign rsp_o.dropped_key = drop_q;

  assign kx  = KW'(cmd_i.key);
  assign yx  = KW'(y_q);
  assign yb  = yx[2*SB-1:SB];
  assign alt = (y_q[SB-1:0] == pos_q) ? yb : y_q[SB-1:0];
  assign v   = byp_q ? bypv_q : rda_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    moves_d     = moves_q;
    op_d        = op_q;
    key_d       = key_q;
    hand_d      = hand_q;
    y_d         = y_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    pos_d       = pos_q;
    alt_d       = alt_q;
    byp_d       = byp_q;
    bypv_d      = bypv_q;
    we          = 1'b0;
    wa          = pos_q;
    wd          = hand_q;
    rd_en       = 1'b0;
    ra_a        = kx[SB-1:0];
    ra_b        = kx[2*SB-1:SB];
    cmd_ready_o = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ok_d        = ok_q;
    oc_d        = oc_q;
    drop_d      = drop_q;

    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        wa    = clr_q;
        wd    = '0;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (cmd_valid_i) begin
          if (cmd_i.zero) begin
            if (out_free) begin
              cmd_ready_o = 1'b1;
              out_valid_d = 1'b1;
              ok_d        = 1'b0;
              oc_d        = cks_pkg::OcZero;
              drop_d      = '0;
            end
          end else begin
            cmd_ready_o = 1'b1;
            rd_en       = 1'b1;
            op_d        = cmd_i.op;
            key_d       = cmd_i.key;
            p0_d        = kx[SB-1:0];
            p1_d        = kx[2*SB-1:SB];
            state_d     = StLook;
          end
        end
      end
      StLook: begin
        if (out_free) begin
          state_d = StIdle;
          drop_d  = '0;
          case (op_q)
            cks_pkg::OpRemove: begin
              out_valid_d = 1'b1;
              wd          = '0;
              if (rda_q == key_q) begin
                we = 1'b1; wa = p0_q; ok_d = 1'b1; oc_d = cks_pkg::OcDone;
              end else if (rdb_q == key_q) begin
                we = 1'b1; wa = p1_q; ok_d = 1'b1; oc_d = cks_pkg::OcDone;
              end else begin
                ok_d = 1'b0; oc_d = cks_pkg::OcAbsent;
              end
            end
            cks_pkg::OpInsert: begin
              wd = key_q;
              if (rda_q == key_q || rdb_q == key_q) begin
                out_valid_d = 1'b1; ok_d = 1'b0; oc_d = cks_pkg::OcPresent;
              end else if (rda_q == '0) begin
                we = 1'b1; wa = p0_q;
                out_valid_d = 1'b1; ok_d = 1'b1; oc_d = cks_pkg::OcDone;
              end else if (rdb_q == '0) begin
                we = 1'b1; wa = p1_q;
                out_valid_d = 1'b1; ok_d = 1'b1; oc_d = cks_pkg::OcDone;
              end else if (limit_q == '0) begin
                out_valid_d = 1'b1; ok_d = 1'b0; oc_d = cks_pkg::OcFull;
                drop_d = key_q;
              end else begin
                hand_d  = key_q;
                pos_d   = p0_q;
                y_d     = rda_q;
                moves_d = '0;
                state_d = StKick;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              if (rda_q == key_q || rdb_q == key_q) begin
                ok_d = 1'b1; oc_d = cks_pkg::OcDone;
              end else begin
                ok_d = 1'b0; oc_d = cks_pkg::OcAbsent;
              end
            end
          endcase
        end
      end
      StKick: begin
        we      = 1'b1;
        wa      = pos_q;
        wd      = hand_q;
        hand_d  = y_q;
        alt_d   = alt;
        rd_en   = 1'b1;
        ra_a    = alt;
        byp_d   = (alt == pos_q);
        bypv_d  = hand_q;
        moves_d = moves_q + 1'b1;
        state_d = StKchk;
      end
      StKchk: begin
        if (out_free) begin
          if (v == '0) begin
            we          = 1'b1;
            wa          = alt_q;
            wd          = hand_q;
            out_valid_d = 1'b1;
            ok_d        = 1'b1;
            oc_d        = cks_pkg::OcDone;
            drop_d      = '0;
            state_d     = StIdle;
          end else if (moves_q == limit_q) begin
            out_valid_d = 1'b1;
            ok_d        = 1'b0;
            oc_d        = cks_pkg::OcFull;
            drop_d      = hand_q;
            state_d     = StIdle;
          end else begin
            y_d     = v;
            pos_d   = alt_q;
            state_d = StKick;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      limit_q     <= cks_pkg::KickReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (kick_limit_we_i) begin
        limit_q <= kick_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    moves_q <= moves_d;
    op_q    <= op_d;
    key_q   <= key_d;
    hand_q  <= hand_d;
    y_q     <= y_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    pos_q   <= pos_d;
    alt_q   <= alt_d;
    byp_q   <= byp_d;
    bypv_q  <= bypv_d;
    ok_q    <= ok_d;
    oc_q    <= oc_d;
    drop_q  <= drop_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rda_q <= mem_q[ra_a];
      rdb_q <= mem_q[ra_b];
    end
  end

endmodule

// ===== sv/cuckoo_hash_set.sv =====
// Cuckoo hash set: top level tying the front stage, command queue and back stage.
//
// Requests come in on req_i (req_type: 0 lookup, 1 insert, 2 remove, 3 treated
// as lookup; key: nonzero 31-bit key) and every request gives exactly one item on
// rsp_o (success, outcome, dropped_key). Both channels move an item when valid and
// ready are high at a rising edge. The table holds 2**SlotBits slots; a key may
// sit at key mod slots or at (key div slots) mod slots.
// The back stage answers a lookup, remove or simple insert after its registered slot
// read, and an insert that kicks makes at most kick_limit displacements.
// Zero keys are answered from the idle state without a slot read.
// After reset the back stage clears every slot of the table, with req_i.ready low;
// kick_limit returns to 32 and may be written at any time through kick_limit_we_i /
// kick_limit_i while the block is idle.
// A stalled rsp_o holds its item; the command queue keeps taking requests until
// it fills, then req_i.ready drops.
module cuckoo_hash_set #(
  parameter int SlotBits = cks_pkg::SlotBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cks_req_if.sink                   req_i,
  cks_rsp_if.source                 rsp_o,
  input  logic                      kick_limit_we_i,
  input  logic [cks_pkg::KickW-1:0] kick_limit_i
);

  logic          fr_valid, fr_ready, q_valid, q_ready, open;
  cks_pkg::cmd_t fr_cmd, q_cmd;

  cks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .open_i      (open),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (fr_ready)
  );

  cks_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_i       (fr_cmd),
    .push_ready_o (fr_ready),
    .pop_valid_o  (q_valid),
    .pop_o        (q_cmd),
    .pop_ready_i  (q_ready)
  );

  cks_back #(
    .SlotBits (SlotBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_cmd),
    .cmd_ready_o     (q_ready),
    .open_o          (open),
    .kick_limit_we_i (kick_limit_we_i),
    .kick_limit_i    (kick_limit_i),
    .rsp_o           (rsp_o)
  );

endmodule
